@@ hdl/leb_pkg.sv @@
// ----------------------------------------------------------------------------
// LEB128 encoder package
// Shared types and constants for the front, queue and back of the encoder.
// ----------------------------------------------------------------------------
package leb_pkg;

  // Encoding modes carried on the action field.
  typedef enum logic [1:0] {
    MODE_U32 = 2'd0,
    MODE_U64 = 2'd1,
    MODE_S32 = 2'd2,
    MODE_S64 = 2'd3
  } mode_t;

  // Longest encoding of a 64-bit value, in bytes.
  localparam int MAX_BYTES = 10;
  localparam int CNT_W     = $clog2(MAX_BYTES);

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [6:0] GROUP_MASK = 7'h7F;
  localparam logic [7:0] CONT_BIT   = 8'h80;

  // One classified item: value already widened to 64 bits.
  typedef struct packed {
    logic [63:0] value;
    logic        is_signed;
    logic        neg;
  } item_t;

endpackage

@@ hdl/leb_front.sv @@
// ----------------------------------------------------------------------------
// LEB128 encoder front
// Accepts input beats, decodes the mode and widens the value to 64 bits.
// ----------------------------------------------------------------------------
module leb_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  logic [1:0]    action,
  input  logic [63:0]   value,
  output logic          push,
  output leb_pkg::item_t push_item,
  input  logic          q_full
);
  import leb_pkg::*;

  logic  f_vld;
  item_t f_item;
  item_t cls;
  logic  accept;

  // Classify the incoming beat by mode.
  always_comb begin
    cls = '0;
    case (mode_t'(action))
      MODE_U32: begin
        cls.value = {32'h0, value[31:0]};
      end
      MODE_U64: begin
        cls.value = value;
      end
      MODE_S32: begin
        cls.value     = {{32{value[31]}}, value[31:0]};
        cls.is_signed = 1'b1;
        cls.neg       = value[31];
      end
      MODE_S64: begin
        cls.value     = value;
        cls.is_signed = 1'b1;
        cls.neg       = value[63];
      end
      default: begin
        cls = '0;
      end
    endcase
  end

  assign item_stall = f_vld && q_full;
  assign accept     = item_valid && !item_stall;
  assign push       = f_vld && !q_full;
  assign push_item  = f_item;

  // Holding register in front of the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (accept) begin
      f_vld <= 1'b1;
    end else if (push) begin
      f_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item <= cls;
    end
  end

endmodule

@@ hdl/leb_queue.sv @@
// ----------------------------------------------------------------------------
// LEB128 encoder queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module leb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  leb_pkg::item_t push_item,
  output logic           q_full,
  input  logic           pop,
  output logic           q_valid,
  output leb_pkg::item_t q_item
);
  import leb_pkg::*;

  item_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;

  localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QPTR_W:0]   FULL_CNT = (QPTR_W + 1)'(QUEUE_DEPTH);

  assign q_full  = (count == FULL_CNT);
  assign q_valid = (count != '0);
  assign q_item  = entries[rd_ptr];

  // Pointer and fill count upkeep.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

@@ hdl/leb_back.sv @@
// ----------------------------------------------------------------------------
// LEB128 encoder back
// Shifts one item out seven bits at a time into a registered output beat.
// ----------------------------------------------------------------------------
module leb_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  leb_pkg::item_t q_item,
  output logic           pop,
  output logic           byte_valid,
  input  logic           byte_stall,
  output logic [7:0]     out_byte,
  output logic           last
);
  import leb_pkg::*;

  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_BYTES - 1);

  logic             busy;
  logic [63:0]      rem;
  logic             is_signed;
  logic             neg;
  logic [CNT_W-1:0] cnt;

  logic [6:0]  grp;
  logic [63:0] rem_next;
  logic        done;
  logic        fin;
  logic        advance;

  // Next group, shifted remainder and stop test.
  always_comb begin
    grp      = rem[6:0] & GROUP_MASK;
    rem_next = {{7{neg}}, rem[63:7]};
    if (is_signed) begin
      done = ((rem_next == '0) && !grp[6]) || ((rem_next == '1) && grp[6]);
    end else begin
      done = (rem_next == '0);
    end
    fin = done || (cnt == LAST_CNT);
  end

  assign advance = busy && (!byte_valid || !byte_stall);
  assign pop     = q_valid && !busy;

  // Sequencer over the groups of one item.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (pop) begin
      busy <= 1'b1;
    end else if (advance && fin) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rem       <= q_item.value;
      is_signed <= q_item.is_signed;
      neg       <= q_item.neg;
      cnt       <= '0;
    end else if (advance) begin
      rem <= rem_next;
      cnt <= cnt + 1'b1;
    end
  end

  // Output beat register.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (advance) begin
      byte_valid <= 1'b1;
    end else if (!byte_stall) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte <= fin ? {1'b0, grp} : (CONT_BIT | {1'b0, grp});
      last     <= fin;
    end
  end

endmodule

@@ hdl/leb128_encoder.sv @@
// An accepted input beat passes through the front register, the queue and the
// shift unit before its first output byte is loaded.
// An item encoding to n bytes (1 to 10) holds the shift unit in the back until
// its last byte is loaded; only then is the next item loaded from the queue.
// Reset (synchronous, active high) empties the front register, the queue and
// the output register; no storage is cleared.
// ----------------------------------------------------------------------------
// LEB128 encoder
// Encodes 32/64-bit unsigned or signed integers into LEB128 byte runs.
// ----------------------------------------------------------------------------
module leb128_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  action,
  input  logic [63:0] value,
  output logic        byte_valid,
  input  logic        byte_stall,
  output logic [7:0]  out_byte,
  output logic        last
);
  import leb_pkg::*;

  logic  push;
  item_t push_item;
  logic  q_full;
  logic  pop;
  logic  q_valid;
  item_t q_item;

  // Front: accept and classify.
  leb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .action     (action),
    .value      (value),
    .push       (push),
    .push_item  (push_item),
    .q_full     (q_full)
  );

  // Queue between the two halves.
  leb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  // Back: emit bytes.
  leb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .pop        (pop),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .out_byte   (out_byte),
    .last       (last)
  );

endmodule

@@ hdl/leb_checker.sv @@
// ----------------------------------------------------------------------------
// LEB128 encoder checker
// Port-level assertions on the output byte stream, bound to the top level.
// ----------------------------------------------------------------------------
module leb_checker (
  input logic        clk,
  input logic        rst,
  input logic        byte_valid,
  input logic        byte_stall,
  input logic [7:0]  out_byte,
  input logic        last
);
  import leb_pkg::*;

  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_BYTES - 1);

  logic [CNT_W-1:0] run_cnt;

  // Count bytes delivered in the current encoding.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_cnt <= '0;
    end else if (byte_valid && !byte_stall) begin
      run_cnt <= last ? '0 : run_cnt + 1'b1;
    end
  end

  // A stalled beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_stall |=> byte_valid && $stable(out_byte) && $stable(last))
    else $error("stalled output beat changed");

  // Continuation bit agrees with the last flag.
  a_cont: assert property (@(posedge clk) disable iff (rst)
    byte_valid |-> (out_byte[7] == !last))
    else $error("continuation bit disagrees with last");

  // No encoding runs past ten bytes.
  a_len: assert property (@(posedge clk) disable iff (rst)
    byte_valid && (run_cnt == LAST_CNT) |-> last)
    else $error("encoding longer than ten bytes");

  // Reset empties the output register.
  a_rst: assert property (@(posedge clk) rst |=> !byte_valid)
    else $error("output valid after reset");

endmodule

bind leb128_encoder leb_checker u_leb_checker (
  .clk        (clk),
  .rst        (rst),
  .byte_valid (byte_valid),
  .byte_stall (byte_stall),
  .out_byte   (out_byte),
  .last       (last)
);
